@@ design/gtg_pkg.sv @@
// Shared types, constants and the arctangent table of the go-to-goal controller
package gtg_pkg;

	// Field widths
	localparam int POS_W   = 16;
	localparam int ANG_W   = 16;
	localparam int TOL_W   = 15;
	localparam int GAIN_W  = 8;
	localparam int SPD_W   = 15;
	localparam int TURN_W  = 16;

	// CORDIC and square root pipeline depth
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_ENTRIES  = 24;
	localparam int CORDIC_N = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
	localparam int SQRT_STEPS = 17;
	localparam int ITER_N = (CORDIC_N > SQRT_STEPS) ? CORDIC_N : SQRT_STEPS;

	// Internal widths
	localparam int DIFF_W  = POS_W + 1;
	localparam int SQR_W   = 2 * (DIFF_W - 1);
	localparam int SQ_W    = 2 * SQRT_STEPS;
	localparam int TOL2_W  = 2 * TOL_W;
	localparam int DIST_W  = SQRT_STEPS;
	localparam int CX_W    = 28;
	localparam int CZ_W    = 24;
	localparam int CX_PRE  = 8;
	localparam int ANG_FRAC = 20;
	localparam int BRG_SH  = ANG_FRAC - 13;
	localparam int BRG_W   = CZ_W - BRG_SH + 1;
	localparam int ERR_W   = 19;
	localparam int E_W     = 17;
	localparam int SPROD_W = DIST_W + GAIN_W;
	localparam int TPROD_W = E_W + GAIN_W + 1;

	localparam logic signed [CZ_W-1:0]  PI_Z       = 24'sd3294199;
	localparam logic signed [CZ_W-1:0]  Z_RND      = 24'sd64;
	localparam logic signed [ERR_W-1:0] PI_Q13     = 19'sd25736;
	localparam logic signed [ERR_W-1:0] NEG_PI_Q13 = -19'sd25736;
	localparam logic signed [ERR_W-1:0] TWO_PI_Q13 = 19'sd51472;
	localparam int SPD_RND  = 8;
	localparam int SPD_SH   = 4;
	localparam int TURN_RND = 32;
	localparam int TURN_SH  = 6;
	localparam int TURN_MAX = 32767;
	localparam int TURN_MIN = -32768;

	// Configuration port
	localparam int REG_IDX_W = 3;
	localparam int APB_AW    = REG_IDX_W + 2;
	localparam int APB_DW    = 32;
	localparam logic [REG_IDX_W-1:0] REG_GOAL_X      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GOAL_Y      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ARRIVE_TOL  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DIST_GAIN   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_HEAD_GAIN   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd5;

	localparam logic [TOL_W-1:0]  TOL_RESET   = 15'd205;
	localparam logic [GAIN_W-1:0] GAIN_RESET  = 8'd80;
	localparam logic [SPD_W-1:0]  LIMIT_RESET = 15'd10240;

	typedef struct packed {
		logic signed [POS_W-1:0] goal_x;
		logic signed [POS_W-1:0] goal_y;
		logic [TOL_W-1:0]        arrive_tolerance;
		logic [GAIN_W-1:0]       distance_gain;
		logic [GAIN_W-1:0]       heading_gain;
		logic [SPD_W-1:0]        speed_limit;
	} cfg_t;

	// One item in flight through the root and CORDIC stages
	typedef struct packed {
		logic [SQ_W-1:0]         rem;
		logic [SQ_W-1:0]         root;
		logic signed [CX_W-1:0]  x;
		logic signed [CX_W-1:0]  y;
		logic signed [CZ_W-1:0]  z;
		logic signed [ANG_W-1:0] head;
		logic                    arrived;
	} lane_t;

	// atan(2^-i) in units of 2^-20 rad
	function automatic logic signed [CZ_W-1:0] atan_entry(input int i);
		logic signed [CZ_W-1:0] r;
		case (i)
			0:  r = 24'sd823550;
			1:  r = 24'sd486170;
			2:  r = 24'sd256879;
			3:  r = 24'sd130396;
			4:  r = 24'sd65451;
			5:  r = 24'sd32757;
			6:  r = 24'sd16383;
			7:  r = 24'sd8192;
			8:  r = 24'sd4096;
			9:  r = 24'sd2048;
			10: r = 24'sd1024;
			11: r = 24'sd512;
			12: r = 24'sd256;
			13: r = 24'sd128;
			14: r = 24'sd64;
			15: r = 24'sd32;
			16: r = 24'sd16;
			17: r = 24'sd8;
			18: r = 24'sd4;
			19: r = 24'sd2;
			20: r = 24'sd1;
			default: r = 24'sd0;
		endcase
		return r;
	endfunction

endpackage

@@ design/gtg_if.sv @@
// Pose and command channel interfaces of the go-to-goal controller
interface gtg_pose_if;
	logic                             valid;
	logic                             ready;
	logic signed [gtg_pkg::POS_W-1:0] pose_x;
	logic signed [gtg_pkg::POS_W-1:0] pose_y;
	logic signed [gtg_pkg::ANG_W-1:0] pose_heading;

	modport source (output valid, pose_x, pose_y, pose_heading, input ready);
	modport sink (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

interface gtg_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [gtg_pkg::SPD_W-1:0]         forward_speed;
	logic signed [gtg_pkg::TURN_W-1:0] turn_rate;
	logic                              arrived;

	modport source (output valid, forward_speed, turn_rate, arrived, input ready);
	modport sink (input valid, forward_speed, turn_rate, arrived, output ready);
endinterface

@@ design/gtg_regs.sv @@
// APB configuration registers of the go-to-goal controller
module gtg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gtg_pkg::APB_AW-1:0]   paddr,
	input  logic [gtg_pkg::APB_DW-1:0]   pwdata,
	output logic [gtg_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	output gtg_pkg::cfg_t                cfg
);
	localparam int IW = gtg_pkg::REG_IDX_W;

	gtg_pkg::cfg_t         cfg_q;
	logic [IW-1:0]         idx;
	logic                  wr_en;

	assign idx    = paddr[IW+1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.goal_x           <= '0;
			cfg_q.goal_y           <= '0;
			cfg_q.arrive_tolerance <= gtg_pkg::TOL_RESET;
			cfg_q.distance_gain    <= gtg_pkg::GAIN_RESET;
			cfg_q.heading_gain     <= gtg_pkg::GAIN_RESET;
			cfg_q.speed_limit      <= gtg_pkg::LIMIT_RESET;
		end else if (wr_en) begin
			case (idx)
				gtg_pkg::REG_GOAL_X:      cfg_q.goal_x <= pwdata[gtg_pkg::POS_W-1:0];
				gtg_pkg::REG_GOAL_Y:      cfg_q.goal_y <= pwdata[gtg_pkg::POS_W-1:0];
				gtg_pkg::REG_ARRIVE_TOL:  cfg_q.arrive_tolerance <= pwdata[gtg_pkg::TOL_W-1:0];
				gtg_pkg::REG_DIST_GAIN:   cfg_q.distance_gain <= pwdata[gtg_pkg::GAIN_W-1:0];
				gtg_pkg::REG_HEAD_GAIN:   cfg_q.heading_gain <= pwdata[gtg_pkg::GAIN_W-1:0];
				gtg_pkg::REG_SPEED_LIMIT: cfg_q.speed_limit <= pwdata[gtg_pkg::SPD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			gtg_pkg::REG_GOAL_X:      prdata[gtg_pkg::POS_W-1:0]  = cfg_q.goal_x;
			gtg_pkg::REG_GOAL_Y:      prdata[gtg_pkg::POS_W-1:0]  = cfg_q.goal_y;
			gtg_pkg::REG_ARRIVE_TOL:  prdata[gtg_pkg::TOL_W-1:0]  = cfg_q.arrive_tolerance;
			gtg_pkg::REG_DIST_GAIN:   prdata[gtg_pkg::GAIN_W-1:0] = cfg_q.distance_gain;
			gtg_pkg::REG_HEAD_GAIN:   prdata[gtg_pkg::GAIN_W-1:0] = cfg_q.heading_gain;
			gtg_pkg::REG_SPEED_LIMIT: prdata[gtg_pkg::SPD_W-1:0]  = cfg_q.speed_limit;
			default:                  prdata = '0;
		endcase
	end

endmodule

@@ design/gtg_front.sv @@
// Front stages: goal offset, squares, arrival test and CORDIC pre-rotation
module gtg_front (
	input  logic           clk,
	input  logic           arst_n,
	input  gtg_pkg::cfg_t  cfg,
	gtg_pose_if.sink       pose,
	output logic           out_valid,
	input  logic           out_ready,
	output gtg_pkg::lane_t out_lane
);
	localparam int POS_W  = gtg_pkg::POS_W;
	localparam int ANG_W  = gtg_pkg::ANG_W;
	localparam int DIFF_W = gtg_pkg::DIFF_W;
	localparam int SQR_W  = gtg_pkg::SQR_W;
	localparam int SQ_W   = gtg_pkg::SQ_W;
	localparam int TOL2_W = gtg_pkg::TOL2_W;
	localparam int CX_W   = gtg_pkg::CX_W;
	localparam int CZ_W   = gtg_pkg::CZ_W;
	localparam int CX_PRE = gtg_pkg::CX_PRE;
	localparam int EXT_W  = CX_W - DIFF_W - CX_PRE;

	logic vld_s1, vld_s2, vld_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic signed [ANG_W-1:0]  head_s1, head_s2;
	logic [SQR_W-1:0]         dx2_s2, dy2_s2;
	logic [TOL2_W-1:0]        tol2_s2;
	logic signed [CX_W-1:0]   x_s2, y_s2;
	logic signed [CZ_W-1:0]   z_s2;
	gtg_pkg::lane_t           lane_s3;

	logic signed [DIFF_W-1:0]   dx_c, dy_c;
	logic signed [2*DIFF_W-1:0] dxx_c, dyy_c;
	logic signed [CX_W-1:0]     x0_c, y0_c, xi_c, yi_c;
	logic signed [CZ_W-1:0]     zi_c;
	logic [SQ_W-1:0]            sq_c;

	// Bubbles close up: a stage takes new data when empty or when it moves on
	assign rdy_s3     = !vld_s3 || out_ready;
	assign rdy_s2     = !vld_s2 || rdy_s3;
	assign rdy_s1     = !vld_s1 || rdy_s2;
	assign pose.ready = rdy_s1;
	assign out_valid  = vld_s3;
	assign out_lane   = lane_s3;

	assign dx_c = {cfg.goal_x[POS_W-1], cfg.goal_x} - {pose.pose_x[POS_W-1], pose.pose_x};
	assign dy_c = {cfg.goal_y[POS_W-1], cfg.goal_y} - {pose.pose_y[POS_W-1], pose.pose_y};

	assign dxx_c = dx_s1 * dx_s1;
	assign dyy_c = dy_s1 * dy_s1;

	// Fold the left half-plane onto the right by a rotation of pi
	always_comb begin
		x0_c = {{EXT_W{dx_s1[DIFF_W-1]}}, dx_s1, {CX_PRE{1'b0}}};
		y0_c = {{EXT_W{dy_s1[DIFF_W-1]}}, dy_s1, {CX_PRE{1'b0}}};
		if (dx_s1[DIFF_W-1]) begin
			xi_c = -x0_c;
			yi_c = -y0_c;
			zi_c = dy_s1[DIFF_W-1] ? -gtg_pkg::PI_Z : gtg_pkg::PI_Z;
		end else begin
			xi_c = x0_c;
			yi_c = y0_c;
			zi_c = '0;
		end
	end

	assign sq_c = SQ_W'(dx2_s2) + SQ_W'(dy2_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= pose.valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && pose.valid) begin
			dx_s1   <= dx_c;
			dy_s1   <= dy_c;
			head_s1 <= pose.pose_heading;
		end
		if (rdy_s2 && vld_s1) begin
			dx2_s2  <= dxx_c[SQR_W-1:0];
			dy2_s2  <= dyy_c[SQR_W-1:0];
			tol2_s2 <= cfg.arrive_tolerance * cfg.arrive_tolerance;
			x_s2    <= xi_c;
			y_s2    <= yi_c;
			z_s2    <= zi_c;
			head_s2 <= head_s1;
		end
		if (rdy_s3 && vld_s2) begin
			lane_s3.rem     <= sq_c;
			lane_s3.root    <= '0;
			lane_s3.x       <= x_s2;
			lane_s3.y       <= y_s2;
			lane_s3.z       <= z_s2;
			lane_s3.head    <= head_s2;
			lane_s3.arrived <= sq_c <= SQ_W'(tol2_s2);
		end
	end

endmodule

@@ design/gtg_iter.sv @@
// Shared stages: a square root digit each, a CORDIC rotation if k < CORDIC_N
module gtg_iter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  gtg_pkg::lane_t in_lane,
	output logic           out_valid,
	input  logic           out_ready,
	output gtg_pkg::lane_t out_lane
);
	localparam int ITER_N     = gtg_pkg::ITER_N;
	localparam int SQ_W       = gtg_pkg::SQ_W;
	localparam int CX_W       = gtg_pkg::CX_W;
	localparam int SQRT_STEPS = gtg_pkg::SQRT_STEPS;
	localparam int CORDIC_N   = gtg_pkg::CORDIC_N;

	// Per-stage registers, indexed by stage
	logic           vld_sk  [ITER_N];
	logic           rdy_sk  [ITER_N+1];
	gtg_pkg::lane_t lane_sk [ITER_N];

	assign rdy_sk[ITER_N] = out_ready;
	assign in_ready       = rdy_sk[0];
	assign out_valid      = vld_sk[ITER_N-1];
	assign out_lane       = lane_sk[ITER_N-1];

	for (genvar k = 0; k < ITER_N; k++) begin : g_stage
		localparam int SQ_SH = (k < SQRT_STEPS) ? SQ_W - 2 - 2 * k : 0;
		localparam int CS    = (k < CORDIC_N) ? k : 0;
		localparam logic [SQ_W-1:0] SQ_BIT = {{(SQ_W-1){1'b0}}, 1'b1} << SQ_SH;

		gtg_pkg::lane_t         src, nxt;
		logic                   src_vld;
		logic [SQ_W:0]          trial;
		logic signed [CX_W-1:0] xs, ys;

		if (k == 0) begin : g_first
			assign src     = in_lane;
			assign src_vld = in_valid;
		end else begin : g_next
			assign src     = lane_sk[k-1];
			assign src_vld = vld_sk[k-1];
		end

		always_comb begin
			nxt   = src;
			trial = {1'b0, src.root} + {1'b0, SQ_BIT};
			xs    = $signed(src.x) >>> CS;
			ys    = $signed(src.y) >>> CS;
			if (k < SQRT_STEPS) begin
				if ({1'b0, src.rem} >= trial) begin
					nxt.rem  = src.rem - trial[SQ_W-1:0];
					nxt.root = (src.root >> 1) + SQ_BIT;
				end else begin
					nxt.root = src.root >> 1;
				end
			end
			// Vectoring: rotate towards the x axis, accumulate the angle
			if (k < CORDIC_N) begin
				if (src.y[CX_W-1]) begin
					nxt.x = src.x - ys;
					nxt.y = src.y + xs;
					nxt.z = src.z - gtg_pkg::atan_entry(k);
				end else begin
					nxt.x = src.x + ys;
					nxt.y = src.y - xs;
					nxt.z = src.z + gtg_pkg::atan_entry(k);
				end
			end
		end

		assign rdy_sk[k] = !vld_sk[k] || rdy_sk[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k] <= 1'b0;
			end else if (rdy_sk[k]) begin
				vld_sk[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_sk[k] && src_vld) begin
				lane_sk[k] <= nxt;
			end
		end
	end

endmodule

@@ design/gtg_back.sv @@
// Back stages: bearing rounding, heading error wrap, gains, limits, output register
module gtg_back (
	input  logic           clk,
	input  logic           arst_n,
	input  gtg_pkg::cfg_t  cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  gtg_pkg::lane_t in_lane,
	gtg_cmd_if.source      cmd
);
	localparam int ANG_W   = gtg_pkg::ANG_W;
	localparam int CZ_W    = gtg_pkg::CZ_W;
	localparam int BRG_W   = gtg_pkg::BRG_W;
	localparam int ERR_W   = gtg_pkg::ERR_W;
	localparam int E_W     = gtg_pkg::E_W;
	localparam int DIST_W  = gtg_pkg::DIST_W;
	localparam int SPROD_W = gtg_pkg::SPROD_W;
	localparam int SRND_W  = SPROD_W + 1;
	localparam int SPD_W   = gtg_pkg::SPD_W;
	localparam int TPROD_W = gtg_pkg::TPROD_W;
	localparam int TS_W    = TPROD_W + 1;
	localparam int TURN_W  = gtg_pkg::TURN_W;
	localparam logic signed [TS_W-1:0] T_MAX = TS_W'(gtg_pkg::TURN_MAX);
	localparam logic signed [TS_W-1:0] T_MIN = TS_W'(gtg_pkg::TURN_MIN);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic signed [BRG_W-1:0]   brg_s1;
	logic signed [ANG_W-1:0]   head_s1;
	logic [SPROD_W-1:0]        sprod_s1;
	logic                      arr_s1;
	logic signed [E_W-1:0]     e_s2;
	logic [SPD_W-1:0]          spd_s2;
	logic                      arr_s2;
	logic signed [TPROD_W-1:0] tprod_s3;
	logic [SPD_W-1:0]          spd_s3;
	logic                      arr_s3;
	logic [SPD_W-1:0]          spd_s4;
	logic signed [TURN_W-1:0]  turn_s4;
	logic                      arr_s4;

	logic signed [CZ_W-1:0]    zr_c;
	logic signed [BRG_W-1:0]   brg_c;
	logic signed [ERR_W-1:0]   err_c, errw_c;
	logic [SRND_W-1:0]         srnd_c, sraw_c;
	logic [SPD_W-1:0]          spd_c;
	logic signed [TS_W-1:0]    tsum_c, tsh_c;
	logic signed [TURN_W-1:0]  turn_c;

	assign rdy_s4   = !vld_s4 || cmd.ready;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign cmd.valid         = vld_s4;
	assign cmd.forward_speed = spd_s4;
	assign cmd.turn_rate     = turn_s4;
	assign cmd.arrived       = arr_s4;

	// Round the CORDIC angle down to Q3.13
	assign zr_c  = in_lane.z + gtg_pkg::Z_RND;
	assign brg_c = BRG_W'(zr_c >>> gtg_pkg::BRG_SH);

	// Wrap into minus pi to pi; one turn is always enough here
	always_comb begin
		err_c = ERR_W'(brg_s1) - ERR_W'(head_s1);
		if (err_c > gtg_pkg::PI_Q13) begin
			errw_c = err_c - gtg_pkg::TWO_PI_Q13;
		end else if (err_c < gtg_pkg::NEG_PI_Q13) begin
			errw_c = err_c + gtg_pkg::TWO_PI_Q13;
		end else begin
			errw_c = err_c;
		end
	end

	always_comb begin
		srnd_c = {1'b0, sprod_s1} + SRND_W'(gtg_pkg::SPD_RND);
		sraw_c = srnd_c >> gtg_pkg::SPD_SH;
		if (sraw_c > SRND_W'(cfg.speed_limit)) begin
			spd_c = cfg.speed_limit;
		end else begin
			spd_c = sraw_c[SPD_W-1:0];
		end
	end

	always_comb begin
		tsum_c = TS_W'(tprod_s3) + TS_W'(gtg_pkg::TURN_RND);
		tsh_c  = tsum_c >>> gtg_pkg::TURN_SH;
		if (tsh_c > T_MAX) begin
			turn_c = T_MAX[TURN_W-1:0];
		end else if (tsh_c < T_MIN) begin
			turn_c = T_MIN[TURN_W-1:0];
		end else begin
			turn_c = tsh_c[TURN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			brg_s1   <= brg_c;
			head_s1  <= in_lane.head;
			sprod_s1 <= in_lane.root[DIST_W-1:0] * cfg.distance_gain;
			arr_s1   <= in_lane.arrived;
		end
		if (rdy_s2 && vld_s1) begin
			e_s2   <= E_W'(errw_c);
			spd_s2 <= spd_c;
			arr_s2 <= arr_s1;
		end
		if (rdy_s3 && vld_s2) begin
			tprod_s3 <= e_s2 * $signed({1'b0, cfg.heading_gain});
			spd_s3   <= spd_s2;
			arr_s3   <= arr_s2;
		end
		if (rdy_s4 && vld_s3) begin
			spd_s4  <= arr_s3 ? '0 : spd_s3;
			turn_s4 <= arr_s3 ? '0 : turn_c;
			arr_s4  <= arr_s3;
		end
	end

	a_arrived_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && arr_s4) |-> (spd_s4 == '0 && turn_s4 == '0))
		else $error("arrival result carries non-zero motion");

	a_error_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (ERR_W'(e_s2) <= gtg_pkg::PI_Q13 && ERR_W'(e_s2) >= gtg_pkg::NEG_PI_Q13))
		else $error("heading error left outside minus pi to pi");

	a_block_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && !cmd.ready))
		else $error("back stages refuse data with a free slot");

endmodule

@@ design/go_to_goal_p_controller.sv @@
// Top level of the go-to-goal proportional steering controller
//
// A pose sample (pose_x, pose_y, pose_heading) is a transfer on the pose
// channel (valid/ready). Each one yields exactly one transfer on the cmd
// channel: forward_speed, turn_rate and arrived, in the order of the poses.
// Goal, tolerance, gains and speed limit sit in APB registers at byte
// addresses 0, 4, 8, 12, 16 and 20; pready is tied high. Change them only
// while no sample is in flight.
// The pipeline depth is set by the 17-step square root running beside the
// CORDIC, one step per register stage, with three stages ahead for offsets
// and squares and four after for the gains.
// One pose is taken every cycle while the command side keeps up.
// Reset clears all stages and loads the register defaults. When the cmd
// side stalls, the output register holds its result and empty stages
// behind it keep filling; pose.ready drops only once every stage is full.
module go_to_goal_p_controller (
	input  logic                       clk,
	input  logic                       arst_n,
	gtg_pose_if.sink                   pose,
	gtg_cmd_if.source                  cmd,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gtg_pkg::APB_AW-1:0] paddr,
	input  logic [gtg_pkg::APB_DW-1:0] pwdata,
	output logic [gtg_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	gtg_pkg::cfg_t  cfg;
	logic           fr_valid, fr_ready;
	gtg_pkg::lane_t fr_lane;
	logic           it_valid, it_ready;
	gtg_pkg::lane_t it_lane;

	gtg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gtg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pose      (pose),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_lane  (fr_lane)
	);

	gtg_iter u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_lane   (fr_lane),
		.out_valid (it_valid),
		.out_ready (it_ready),
		.out_lane  (it_lane)
	);

	gtg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (it_valid),
		.in_ready (it_ready),
		.in_lane  (it_lane),
		.cmd      (cmd)
	);

endmodule

@@ sim/tb_go_to_goal_p_controller.sv @@
// Testbench of the go-to-goal controller: random and directed poses checked against a local predictor
`timescale 1ns / 1ps

module tb_go_to_goal_p_controller;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 64;
	localparam logic [gtg_pkg::REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [gtg_pkg::REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic [gtg_pkg::SPD_W-1:0]         forward_speed;
		logic signed [gtg_pkg::TURN_W-1:0] turn_rate;
		logic                              arrived;
	} motion_cmd_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [gtg_pkg::APB_AW-1:0] paddr;
	logic [gtg_pkg::APB_DW-1:0] pwdata;
	logic [gtg_pkg::APB_DW-1:0] prdata;
	logic pready;

	gtg_pose_if pose_ch ();
	gtg_cmd_if  cmd_ch ();

	go_to_goal_p_controller u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pose    (pose_ch),
		.cmd     (cmd_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	gtg_pkg::cfg_t ctl_cfg;
	motion_cmd_t   cmd_expected_q[$];
	int            mismatches = 0;
	int            idle_cycles = 0;
	bit            pose_throttle = 1'b1;
	bit            cmd_throttle = 1'b1;
	bit            cmd_hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly no gap, some short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic int pick_level(int top);
		int r;
		r = $urandom_range(5);
		if (r == 0)
			return 0;
		else if (r == 1)
			return top;
		return $urandom_range(top);
	endfunction

	function automatic longint root_floor(longint v);
		longint res;
		longint bitv;
		res = 0;
		bitv = longint'(1) << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Vectoring CORDIC on the goal offset, angle in 2^-20 rad, result in Q3.13
	function automatic longint goal_bearing(longint dx, longint dy);
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		longint step;
		x = dx * 256;
		y = dy * 256;
		z = 0;
		if (dx < 0) begin
			z = (dy >= 0) ? longint'(gtg_pkg::PI_Z) : -longint'(gtg_pkg::PI_Z);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < gtg_pkg::CORDIC_N; i++) begin
			step = $rtoi($atan(1.0 / (2.0 ** i)) * 1048576.0 + 0.5);
			xs = x >>> i;
			ys = y >>> i;
			if (y < 0) begin
				x = x - ys;
				y = y + xs;
				z = z - step;
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + step;
			end
		end
		return (z + 64) >>> 7;
	endfunction

	function automatic motion_cmd_t predict_motion(logic signed [gtg_pkg::POS_W-1:0] px,
			logic signed [gtg_pkg::POS_W-1:0] py, logic signed [gtg_pkg::ANG_W-1:0] ph);
		motion_cmd_t r;
		longint dx;
		longint dy;
		longint tol;
		longint dgain;
		longint hgain;
		longint limit;
		longint speed;
		longint err;
		longint turn;
		dx = longint'($signed(ctl_cfg.goal_x)) - longint'(px);
		dy = longint'($signed(ctl_cfg.goal_y)) - longint'(py);
		tol = ctl_cfg.arrive_tolerance;
		dgain = ctl_cfg.distance_gain;
		hgain = ctl_cfg.heading_gain;
		limit = ctl_cfg.speed_limit;
		r = '0;
		if (dx * dx + dy * dy <= tol * tol) begin
			r.arrived = 1'b1;
			return r;
		end
		speed = (root_floor(dx * dx + dy * dy) * dgain + 8) >>> 4;
		if (speed > limit)
			speed = limit;
		err = goal_bearing(dx, dy) - longint'(ph);
		while (err > longint'(gtg_pkg::PI_Q13))
			err = err - longint'(gtg_pkg::TWO_PI_Q13);
		while (err < -longint'(gtg_pkg::PI_Q13))
			err = err + longint'(gtg_pkg::TWO_PI_Q13);
		turn = (err * hgain + 32) >>> 6;
		if (turn > gtg_pkg::TURN_MAX)
			turn = gtg_pkg::TURN_MAX;
		if (turn < gtg_pkg::TURN_MIN)
			turn = gtg_pkg::TURN_MIN;
		r.forward_speed = speed[gtg_pkg::SPD_W-1:0];
		r.turn_rate = turn[gtg_pkg::TURN_W-1:0];
		return r;
	endfunction

	function automatic void store_reg(logic [gtg_pkg::REG_IDX_W-1:0] idx,
			logic [gtg_pkg::APB_DW-1:0] v);
		case (idx)
			gtg_pkg::REG_GOAL_X:      ctl_cfg.goal_x = v[gtg_pkg::POS_W-1:0];
			gtg_pkg::REG_GOAL_Y:      ctl_cfg.goal_y = v[gtg_pkg::POS_W-1:0];
			gtg_pkg::REG_ARRIVE_TOL:  ctl_cfg.arrive_tolerance = v[gtg_pkg::TOL_W-1:0];
			gtg_pkg::REG_DIST_GAIN:   ctl_cfg.distance_gain = v[gtg_pkg::GAIN_W-1:0];
			gtg_pkg::REG_HEAD_GAIN:   ctl_cfg.heading_gain = v[gtg_pkg::GAIN_W-1:0];
			gtg_pkg::REG_SPEED_LIMIT: ctl_cfg.speed_limit = v[gtg_pkg::SPD_W-1:0];
			default: ;
		endcase
	endfunction

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			if (mismatches < 50)
				$display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Lower valid and hold until every command in flight has come out
	task automatic wait_drained();
		pose_ch.valid <= 1'b0;
		while (cmd_expected_q.size() != 0)
			@(posedge clk);
	endtask

	// Setup phase, access phase, then psel low again before the next transfer
	task automatic write_reg(logic [gtg_pkg::REG_IDX_W-1:0] idx,
			logic [gtg_pkg::APB_DW-1:0] v);
		wait_drained();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		store_reg(idx, v);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pose(logic signed [gtg_pkg::POS_W-1:0] px,
			logic signed [gtg_pkg::POS_W-1:0] py, logic signed [gtg_pkg::ANG_W-1:0] ph);
		int gap;
		pose_ch.valid <= 1'b1;
		pose_ch.pose_x <= px;
		pose_ch.pose_y <= py;
		pose_ch.pose_heading <= ph;
		do
			@(posedge clk);
		while (!pose_ch.ready);
		cmd_expected_q.push_back(predict_motion(px, py, ph));
		gap = pose_throttle ? gap_len() : 0;
		if (gap > 0) begin
			pose_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// A quarter of the poses land near the goal so that arrival is hit both ways
	task automatic send_random_pose();
		int span;
		logic signed [gtg_pkg::POS_W-1:0] px;
		logic signed [gtg_pkg::POS_W-1:0] py;
		logic signed [gtg_pkg::ANG_W-1:0] ph;
		if ($urandom_range(3) == 0) begin
			span = 2 * int'(ctl_cfg.arrive_tolerance) + 4;
			px = gtg_pkg::POS_W'(int'($signed(ctl_cfg.goal_x))
				+ int'($urandom_range(2 * span)) - span);
			py = gtg_pkg::POS_W'(int'($signed(ctl_cfg.goal_y))
				+ int'($urandom_range(2 * span)) - span);
		end else begin
			px = gtg_pkg::POS_W'($urandom());
			py = gtg_pkg::POS_W'($urandom());
		end
		if ($urandom_range(7) == 0)
			ph = gtg_pkg::ANG_W'($urandom());
		else
			ph = gtg_pkg::ANG_W'(int'($urandom_range(2 * int'(gtg_pkg::PI_Q13)))
				- int'(gtg_pkg::PI_Q13));
		send_pose(px, py, ph);
	endtask

	task automatic test_arrival_boundary();
		send_pose(16'sd0, 16'sd0, 16'sd0);
		send_pose(16'sd205, 16'sd0, 16'sd1000);
		send_pose(16'sd206, 16'sd0, 16'sd0);
		send_pose(16'sd145, 16'sd145, -16'sd300);
		send_pose(-16'sd144, -16'sd145, 16'sd0);
	endtask

	task automatic test_bearing_quadrants();
		send_pose(16'sd1000, 16'sd0, 16'sd0);
		send_pose(16'sd1000, 16'sd1, 16'sd0);
		send_pose(16'sd0, -16'sd1000, 16'sd0);
		send_pose(16'sd0, 16'sd1000, 16'sd0);
		send_pose(16'sd1000, 16'sd0, -16'sd25736);
		send_pose(-16'sd1000, 16'sd0, 16'sd25736);
		// heading beyond pi either way still wraps
		send_pose(16'sd1000, -16'sd1000, 16'sh7fff);
		send_pose(-16'sd1000, 16'sd1000, 16'sh8000);
	endtask

	task automatic test_register_extremes();
		write_reg(gtg_pkg::REG_GOAL_X, 32'h1234_8000);
		write_reg(gtg_pkg::REG_GOAL_Y, 32'h0000_7fff);
		write_reg(gtg_pkg::REG_ARRIVE_TOL, 32'h0);
		write_reg(gtg_pkg::REG_DIST_GAIN, 32'hff);
		write_reg(gtg_pkg::REG_HEAD_GAIN, 32'hff);
		write_reg(gtg_pkg::REG_SPEED_LIMIT, 32'h7fff);
		// writes outside the register map are dropped
		write_reg(REG_SPARE_A, $urandom());
		write_reg(REG_SPARE_B, $urandom());
		send_pose(16'sh7fff, 16'sh8000, 16'sd25736);
		send_pose(16'sh7fff, 16'sh8000, -16'sd25736);
		send_pose(16'sh8000, 16'sh7fff, 16'sd0);
		send_pose(16'sh8001, 16'sh7fff, 16'sd0);
		send_pose(16'sh8000, 16'sh0000, 16'sd12000);
		write_reg(gtg_pkg::REG_DIST_GAIN, 32'h0);
		write_reg(gtg_pkg::REG_HEAD_GAIN, 32'h0);
		write_reg(gtg_pkg::REG_SPEED_LIMIT, 32'h0);
		send_pose(16'sd0, 16'sd0, 16'sd5000);
		send_pose(16'sh7fff, 16'sh8000, -16'sd5000);
	endtask

	task automatic test_random_runs();
		for (int run = 0; run < 8; run++) begin
			write_reg(gtg_pkg::REG_GOAL_X, $urandom());
			write_reg(gtg_pkg::REG_GOAL_Y, $urandom());
			if (run == 0)
				write_reg(gtg_pkg::REG_ARRIVE_TOL, 32'h0);
			else if (run == 1)
				write_reg(gtg_pkg::REG_ARRIVE_TOL, 32'h7fff);
			else if (run % 2 == 0)
				write_reg(gtg_pkg::REG_ARRIVE_TOL, $urandom_range(2000));
			else
				write_reg(gtg_pkg::REG_ARRIVE_TOL, pick_level(32767));
			write_reg(gtg_pkg::REG_DIST_GAIN, pick_level(255));
			write_reg(gtg_pkg::REG_HEAD_GAIN, pick_level(255));
			write_reg(gtg_pkg::REG_SPEED_LIMIT, pick_level(32767));
			pose_throttle = (run % 3 != 0);
			cmd_throttle = (run % 4 != 1);
			repeat (160) send_random_pose();
		end
		pose_throttle = 1'b1;
		cmd_throttle = 1'b1;
	endtask

	// Hold the command side off so the pipeline fills and stalls the pose side
	task automatic test_backpressure();
		cmd_hold_req = 1'b1;
		pose_throttle = 1'b0;
		repeat (60) send_random_pose();
		pose_throttle = 1'b1;
	endtask

	task automatic test_drain_pause();
		repeat (40) send_random_pose();
		wait_drained();
		repeat (40) send_random_pose();
	endtask

	// Command side: random stalls, or one long hold-off on request
	initial begin
		cmd_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (cmd_hold_req) begin
				cmd_hold_req = 1'b0;
				cmd_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				cmd_ch.ready <= 1'b1;
			end else if (cmd_throttle && $urandom_range(3) == 0) begin
				cmd_ch.ready <= 1'b0;
				repeat (gap_len() + 1) @(posedge clk);
				cmd_ch.ready <= 1'b1;
			end else begin
				cmd_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		motion_cmd_t want;
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			if (cmd_expected_q.size() == 0) begin
				if (mismatches < 50)
					$display("%0t unexpected transfer: speed %0d turn %0d arrived %0d", $time,
						cmd_ch.forward_speed, cmd_ch.turn_rate, cmd_ch.arrived);
				mismatches++;
			end else begin
				want = cmd_expected_q.pop_front();
				check_field("forward_speed", want.forward_speed, cmd_ch.forward_speed);
				check_field("turn_rate", want.turn_rate, cmd_ch.turn_rate);
				check_field("arrived", want.arrived, cmd_ch.arrived);
			end
		end
	end

	always @(posedge clk) begin
		if ((pose_ch.valid && pose_ch.ready) || (cmd_ch.valid && cmd_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pose_ch.valid = 1'b0;
		pose_ch.pose_x = '0;
		pose_ch.pose_y = '0;
		pose_ch.pose_heading = '0;
		ctl_cfg = '{goal_x: '0, goal_y: '0, arrive_tolerance: gtg_pkg::TOL_RESET,
			distance_gain: gtg_pkg::GAIN_RESET, heading_gain: gtg_pkg::GAIN_RESET,
			speed_limit: gtg_pkg::LIMIT_RESET};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_arrival_boundary();
		test_bearing_quadrants();
		test_register_extremes();
		test_random_runs();
		test_backpressure();
		test_drain_pause();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ go_to_goal_p_controller.f @@
design/gtg_pkg.sv
design/gtg_if.sv
design/gtg_regs.sv
design/gtg_front.sv
design/gtg_iter.sv
design/gtg_back.sv
design/go_to_goal_p_controller.sv
sim/tb_go_to_goal_p_controller.sv
